/* src/assert_macros.svh */
// Assertion macros for the checker file of the convolver.
// Depends on nothing; the user module must provide aclk and aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define FIRCV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent, reset included.
`define FIRCV_ASSERT_NEXT_NORST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/fircv_pkg.sv */
// Package of the stereo FIR convolver: sizes, codes and interface structs.
// Depends on nothing; every module of the block imports it.
package fircv_pkg;

    localparam int MAX_TAPS    = 256;
    localparam int SAMPLE_BITS = 24;
    localparam int TAP_BITS    = 18;

    localparam int ADDR_W   = $clog2(MAX_TAPS);
    localparam int CNT_W    = $clog2(MAX_TAPS + 1);
    localparam int CFG_W    = 9;
    localparam int ACTION_W = 2;
    localparam int INDEX_W  = 8;
    localparam int PROD_W   = SAMPLE_BITS + TAP_BITS;
    localparam int ACC_W    = PROD_W + ADDR_W + 1;

    localparam logic [CFG_W-1:0] ACTIVE_TAPS_RST = CFG_W'(256);
    localparam logic signed [TAP_BITS-1:0] TAP_ONE = {1'b0, {(TAP_BITS-1){1'b1}}};

    typedef enum logic [ACTION_W-1:0] {
        ACT_SAMPLE   = 2'd0,
        ACT_WR_LEFT  = 2'd1,
        ACT_WR_RIGHT = 2'd2
    } fircv_action_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } fircv_state_t;

    typedef struct packed {
        logic                          hist_we;
        logic [ADDR_W-1:0]             hist_waddr;
        logic signed [SAMPLE_BITS-1:0] hist_wdata;
        logic                          tap_we_l;
        logic                          tap_we_r;
        logic [ADDR_W-1:0]             tap_waddr;
        logic signed [TAP_BITS-1:0]    tap_wdata_l;
        logic signed [TAP_BITS-1:0]    tap_wdata_r;
        logic                          rd_en;
        logic [ADDR_W-1:0]             hist_raddr;
        logic [ADDR_W-1:0]             tap_raddr;
    } fircv_mem_req_t;

    typedef struct packed {
        logic clear;
        logic issue;
    } fircv_mac_ctl_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic                          clipped;
    } fircv_result_t;

endpackage

/* src/fircv_store.sv */
// Sample history memory and paired left/right coefficient memory.
// Both are synchronous with registered read data; depends on fircv_pkg.
module fircv_store import fircv_pkg::*; (
    input  logic                          aclk,
    input  fircv_mem_req_t                req,
    output logic signed [SAMPLE_BITS-1:0] hist_rdata,
    output logic signed [TAP_BITS-1:0]    ltap_rdata,
    output logic signed [TAP_BITS-1:0]    rtap_rdata
);

    logic [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
    logic [2*TAP_BITS-1:0]  tap_mem  [MAX_TAPS];

    logic [SAMPLE_BITS-1:0] hist_rdata_reg;
    logic [2*TAP_BITS-1:0]  tap_rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.hist_we) begin
            hist_mem[req.hist_waddr] <= req.hist_wdata;
        end
        if (req.rd_en) begin
            hist_rdata_reg <= hist_mem[req.hist_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.tap_we_l) begin
            tap_mem[req.tap_waddr][2*TAP_BITS-1:TAP_BITS] <= req.tap_wdata_l;
        end
        if (req.tap_we_r) begin
            tap_mem[req.tap_waddr][TAP_BITS-1:0] <= req.tap_wdata_r;
        end
        if (req.rd_en) begin
            tap_rdata_reg <= tap_mem[req.tap_raddr];
        end
    end

    assign hist_rdata = $signed(hist_rdata_reg);
    assign ltap_rdata = $signed(tap_rdata_reg[2*TAP_BITS-1:TAP_BITS]);
    assign rtap_rdata = $signed(tap_rdata_reg[TAP_BITS-1:0]);

endmodule

/* src/fircv_mac.sv */
// Dual multiply-accumulate datapath with rounding and saturation.
// One product pair per cycle, registered before accumulation; depends on fircv_pkg.
module fircv_mac import fircv_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fircv_mac_ctl_t                ctl,
    input  logic signed [SAMPLE_BITS-1:0] hist_rdata,
    input  logic signed [TAP_BITS-1:0]    ltap_rdata,
    input  logic signed [TAP_BITS-1:0]    rtap_rdata,
    output logic                          busy,
    output fircv_result_t                 result
);

    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        {{(ACC_W-TAP_BITS+1){1'b0}}, 1'b1, {(TAP_BITS-2){1'b0}}};
    localparam logic signed [ACC_W-1:0] SAT_HI =
        {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    logic                     rd_vld_reg;
    logic                     prod_vld_reg;
    logic signed [PROD_W-1:0] prod_l_reg;
    logic signed [PROD_W-1:0] prod_r_reg;
    logic signed [ACC_W-1:0]  acc_l_reg;
    logic signed [ACC_W-1:0]  acc_r_reg;
    logic [SAMPLE_BITS:0]     fin_l;
    logic [SAMPLE_BITS:0]     fin_r;

    function automatic logic [SAMPLE_BITS:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] rnd;
        logic signed [ACC_W-1:0] sh;
        rnd = acc + ROUND_HALF;
        sh  = rnd >>> (TAP_BITS - 1);
        priority if (sh > SAT_HI) begin
            return {1'b1, SAT_HI[SAMPLE_BITS-1:0]};
        end else if (sh < SAT_LO) begin
            return {1'b1, SAT_LO[SAMPLE_BITS-1:0]};
        end else begin
            return {1'b0, sh[SAMPLE_BITS-1:0]};
        end
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= ctl.issue;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            prod_l_reg <= hist_rdata * ltap_rdata;
            prod_r_reg <= hist_rdata * rtap_rdata;
        end
        if (ctl.clear) begin
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_l_reg <= acc_l_reg + ACC_W'(prod_l_reg);
            acc_r_reg <= acc_r_reg + ACC_W'(prod_r_reg);
        end
    end

    always_comb begin
        fin_l            = round_sat(acc_l_reg);
        fin_r            = round_sat(acc_r_reg);
        result.left_out  = $signed(fin_l[SAMPLE_BITS-1:0]);
        result.right_out = $signed(fin_r[SAMPLE_BITS-1:0]);
        result.clipped   = fin_l[SAMPLE_BITS] | fin_r[SAMPLE_BITS];
    end

    assign busy = rd_vld_reg | prod_vld_reg;

endmodule

/* src/fircv_ctrl.sv */
// Sequencer: clearing pass, input decode, tap and history addressing.
// Holds the active tap count register; depends on fircv_pkg.
module fircv_ctrl import fircv_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ACTION_W-1:0]           s_action,
    input  logic [INDEX_W-1:0]            s_tap_index,
    input  logic signed [TAP_BITS-1:0]    s_coefficient,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          mac_busy,
    input  logic                          out_free,
    output fircv_mem_req_t                mem_req,
    output fircv_mac_ctl_t                mac_ctl,
    output logic                          out_load
);

    fircv_state_t      state_reg, state_next;
    logic [CFG_W-1:0]  active_taps_reg;
    logic [ADDR_W-1:0] hist_ptr_reg, hist_ptr_next;
    logic [ADDR_W-1:0] hist_addr_reg, hist_addr_next;
    logic [ADDR_W-1:0] tap_addr_reg, tap_addr_next;
    logic [ADDR_W-1:0] last_reg, last_next;
    logic [CNT_W-1:0]  n_eff;
    logic              idx_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            hist_ptr_reg  <= '0;
            hist_addr_reg <= '0;
            tap_addr_reg  <= '0;
            last_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            hist_ptr_reg  <= hist_ptr_next;
            hist_addr_reg <= hist_addr_next;
            tap_addr_reg  <= tap_addr_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_taps_reg <= ACTIVE_TAPS_RST;
        end else if (cfg_valid) begin
            active_taps_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;
    assign idx_ok    = int'(s_tap_index) < MAX_TAPS;

    always_comb begin
        priority if (active_taps_reg == '0) begin
            n_eff = CNT_W'(1);
        end else if (int'(active_taps_reg) > MAX_TAPS) begin
            n_eff = CNT_W'(MAX_TAPS);
        end else begin
            n_eff = CNT_W'(active_taps_reg);
        end
    end

    always_comb begin
        state_next          = state_reg;
        hist_ptr_next       = hist_ptr_reg;
        hist_addr_next      = hist_addr_reg;
        tap_addr_next       = tap_addr_reg;
        last_next           = last_reg;
        s_ready             = (state_reg == ST_IDLE);
        out_load            = 1'b0;
        mac_ctl             = '0;
        mem_req             = '0;
        mem_req.hist_raddr  = hist_addr_reg;
        mem_req.tap_raddr   = tap_addr_reg;
        mem_req.hist_waddr  = hist_ptr_reg;
        mem_req.hist_wdata  = s_sample_in;
        mem_req.tap_waddr   = ADDR_W'(s_tap_index);
        mem_req.tap_wdata_l = s_coefficient;
        mem_req.tap_wdata_r = s_coefficient;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_req.hist_we    = 1'b1;
                mem_req.hist_waddr = tap_addr_reg;
                mem_req.hist_wdata = '0;
                mem_req.tap_we_l   = 1'b1;
                mem_req.tap_we_r   = 1'b1;
                mem_req.tap_waddr  = tap_addr_reg;
                mem_req.tap_wdata_l = (tap_addr_reg == '0) ? TAP_ONE : '0;
                mem_req.tap_wdata_r = (tap_addr_reg == '0) ? TAP_ONE : '0;
                tap_addr_next      = tap_addr_reg + 1'b1;
                if (tap_addr_reg == ADDR_W'(MAX_TAPS - 1)) begin
                    tap_addr_next = '0;
                    state_next    = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (s_action)
                        ACT_SAMPLE: begin
                            mem_req.hist_we = 1'b1;
                            hist_addr_next  = hist_ptr_reg;
                            hist_ptr_next   = (hist_ptr_reg == ADDR_W'(MAX_TAPS - 1)) ?
                                              '0 : hist_ptr_reg + 1'b1;
                            tap_addr_next   = '0;
                            last_next       = ADDR_W'(n_eff - CNT_W'(1));
                            mac_ctl.clear   = 1'b1;
                            state_next      = ST_RUN;
                        end
                        ACT_WR_LEFT: begin
                            mem_req.tap_we_l = idx_ok;
                        end
                        ACT_WR_RIGHT: begin
                            mem_req.tap_we_r = idx_ok;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                mem_req.rd_en  = 1'b1;
                mac_ctl.issue  = 1'b1;
                tap_addr_next  = tap_addr_reg + 1'b1;
                hist_addr_next = (hist_addr_reg == '0) ?
                                 ADDR_W'(MAX_TAPS - 1) : hist_addr_reg - 1'b1;
                if (tap_addr_reg == last_reg) begin
                    tap_addr_next = '0;
                    state_next    = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!mac_busy && out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

endmodule

/* src/binaural_stereo_fir_convolver_top.sv */
// Mono-to-stereo FIR convolver, top level. Uses fircv_pkg, fircv_ctrl, fircv_store, fircv_mac.
// A sample transfer starts one read of the history and coefficient memories per tap, for n taps,
// n being active_taps clamped to 1..256, and its result is then loaded into the result register.
// s_ready stays low until that load; tap writes keep s_ready high and are taken back to back.
// Reset clears control state, then a clearing pass (s_ready low) zeroes the history and loads
// unit impulses into both tap sets. The result register frees the input side.
module binaural_stereo_fir_convolver_top import fircv_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ACTION_W-1:0]           s_action,
    input  logic [INDEX_W-1:0]            s_tap_index,
    input  logic signed [TAP_BITS-1:0]    s_coefficient,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_left_out,
    output logic signed [SAMPLE_BITS-1:0] m_right_out,
    output logic                          m_clipped,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_W-1:0]              cfg_data
);

    fircv_mem_req_t                mem_req;
    fircv_mac_ctl_t                mac_ctl;
    fircv_result_t                 result;
    logic signed [SAMPLE_BITS-1:0] hist_rdata;
    logic signed [TAP_BITS-1:0]    ltap_rdata;
    logic signed [TAP_BITS-1:0]    rtap_rdata;
    logic                          mac_busy;
    logic                          out_free;
    logic                          out_load;
    logic                          m_valid_reg;
    fircv_result_t                 result_reg;

    fircv_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_tap_index   (s_tap_index),
        .s_coefficient (s_coefficient),
        .s_sample_in   (s_sample_in),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mac_busy      (mac_busy),
        .out_free      (out_free),
        .mem_req       (mem_req),
        .mac_ctl       (mac_ctl),
        .out_load      (out_load)
    );

    fircv_store u_store (
        .aclk       (aclk),
        .req        (mem_req),
        .hist_rdata (hist_rdata),
        .ltap_rdata (ltap_rdata),
        .rtap_rdata (rtap_rdata)
    );

    fircv_mac u_mac (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (mac_ctl),
        .hist_rdata (hist_rdata),
        .ltap_rdata (ltap_rdata),
        .rtap_rdata (rtap_rdata),
        .busy       (mac_busy),
        .result     (result)
    );

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            result_reg <= result;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_left_out  = result_reg.left_out;
    assign m_right_out = result_reg.right_out;
    assign m_clipped   = result_reg.clipped;

endmodule

/* src/fircv_checker.sv */
// Port-level checker for the convolver top level, attached by bind.
// Depends on fircv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fircv_checker import fircv_pkg::*; (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic [ACTION_W-1:0] s_action,
    input logic                m_valid,
    input logic                m_ready
);

    `FIRCV_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid, "Result dropped before its transfer.")
    `FIRCV_ASSERT_NEXT(a_sample_busy, s_valid && s_ready && s_action == ACT_SAMPLE, !s_ready, "Input taken while a sample is in progress.")
    `FIRCV_ASSERT_NEXT(a_no_tap_result, s_valid && s_ready && s_action != ACT_SAMPLE && !m_valid, !m_valid, "A tap write or unused action produced a result.")
    `FIRCV_ASSERT_NEXT_NORST(a_reset_quiet, !aresetn, !s_ready && !m_valid, "Ports not quiet after reset.")

endmodule

bind binaural_stereo_fir_convolver_top fircv_checker u_fircv_checker (.*);

/* sim/binaural_stereo_fir_convolver_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for binaural_stereo_fir_convolver_top: random and directed transfers
// checked against a built-in dual FIR predictor. Depends on fircv_pkg and the convolver RTL.
module binaural_stereo_fir_convolver_top_test;
    import fircv_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam longint OUT_MAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
    localparam longint OUT_MIN = -OUT_MAX - 64'sd1;
    localparam logic signed [TAP_BITS-1:0] TAP_MAX = {1'b0, {(TAP_BITS-1){1'b1}}};
    localparam logic signed [TAP_BITS-1:0] TAP_MIN = {1'b1, {(TAP_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] PCM_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] PCM_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam int SETTLE_CYCLES = MAX_TAPS + 8;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int NUM_PHASES = 11;

    typedef struct packed {
        logic [ACTION_W-1:0]           action;
        logic [INDEX_W-1:0]            tap_index;
        logic signed [TAP_BITS-1:0]    coefficient;
        logic signed [SAMPLE_BITS-1:0] sample;
    } stim_item_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [ACTION_W-1:0]           s_action = '0;
    logic [INDEX_W-1:0]            s_tap_index = '0;
    logic signed [TAP_BITS-1:0]    s_coefficient = '0;
    logic signed [SAMPLE_BITS-1:0] s_sample_in = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] m_left_out;
    logic signed [SAMPLE_BITS-1:0] m_right_out;
    logic                          m_clipped;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [CFG_W-1:0]              cfg_data = '0;

    stim_item_t    item_queue[$];
    stim_item_t    on_bus;
    fircv_result_t stereo_expected[$];
    int            items_queued = 0;
    int            items_taken = 0;
    int            mismatches = 0;
    int            cycle_count = 0;
    int            src_idle_pct = 0;
    int            sink_stall_pct = 0;
    logic          hold_wanted = 1'b0;
    logic          hold_done = 1'b0;
    int            hold_left = 0;

    logic signed [SAMPLE_BITS-1:0] hist_line [MAX_TAPS];
    logic signed [TAP_BITS-1:0]    left_resp [MAX_TAPS];
    logic signed [TAP_BITS-1:0]    right_resp [MAX_TAPS];
    logic [ADDR_W-1:0]             hist_ptr;
    logic [CFG_W-1:0]              tap_count_reg;

    int plan_taps [NUM_PHASES] = '{0, 1, 2, 7, 5, 16, 64, 255, 256, 511, 300};
    int plan_load [NUM_PHASES] = '{1, 0, 1, 1, 1, 1, 1, 1, 0, 0, 0};
    int plan_items [NUM_PHASES] = '{100, 100, 130, 130, 130, 130, 100, 50, 50, 40, 30};
    int plan_src [NUM_PHASES] = '{0, 76, 0, 16, 0, 76, 0, 16, 0, 76, 0};
    int plan_sink [NUM_PHASES] = '{0, 0, 76, 16, 0, 0, 76, 16, 0, 0, 76};
    int plan_bits [NUM_PHASES] = '{18, 18, 18, 16, 16, 14, 12, 10, 10, 10, 10};
    int plan_hold [NUM_PHASES] = '{0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0};

    binaural_stereo_fir_convolver_top DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_action     (s_action),
        .s_tap_index  (s_tap_index),
        .s_coefficient(s_coefficient),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_left_out   (m_left_out),
        .m_right_out  (m_right_out),
        .m_clipped    (m_clipped),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int used_taps(input logic [CFG_W-1:0] value);
        if (value == 0) return 1;
        if (value > MAX_TAPS) return MAX_TAPS;
        return int'(value);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(input longint acc,
                                                                output bit sat);
        longint q;
        q = (acc + (64'sd1 <<< (TAP_BITS - 2))) >>> (TAP_BITS - 1);
        sat = 1'b0;
        if (q > OUT_MAX) begin
            q = OUT_MAX;
            sat = 1'b1;
        end else if (q < OUT_MIN) begin
            q = OUT_MIN;
            sat = 1'b1;
        end
        return q[SAMPLE_BITS-1:0];
    endfunction

    task automatic convolve_item(input stim_item_t it);
        int                n;
        int                j;
        longint            acc_l;
        longint            acc_r;
        logic [ADDR_W-1:0] rd;
        bit                sat_l;
        bit                sat_r;
        fircv_result_t     res;
        case (it.action)
            ACT_WR_LEFT: left_resp[it.tap_index] = it.coefficient;
            ACT_WR_RIGHT: right_resp[it.tap_index] = it.coefficient;
            ACT_SAMPLE: begin
                n = used_taps(tap_count_reg);
                hist_line[hist_ptr] = it.sample;
                acc_l = 0;
                acc_r = 0;
                for (j = 0; j < n; j++) begin
                    rd = hist_ptr - ADDR_W'(j);
                    acc_l += longint'(hist_line[rd]) * longint'(left_resp[j]);
                    acc_r += longint'(hist_line[rd]) * longint'(right_resp[j]);
                end
                res.left_out = round_sat(acc_l, sat_l);
                res.right_out = round_sat(acc_r, sat_r);
                res.clipped = sat_l | sat_r;
                stereo_expected.insert(stereo_expected.size(), res);
                hist_ptr = hist_ptr + 1'b1;
            end
            default: ;
        endcase
    endtask

    function automatic logic signed [TAP_BITS-1:0] rand_coef(input int bits);
        int                 pick;
        logic signed [31:0] v;
        pick = $urandom_range(99);
        if (pick < 4) return TAP_MIN;
        if (pick < 8) return TAP_MAX;
        if (pick < 10) return '0;
        v = $urandom;
        v = (v <<< (32 - bits)) >>> (32 - bits);
        return v[TAP_BITS-1:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        int                 pick;
        logic signed [31:0] v;
        pick = $urandom_range(99);
        if (pick < 5) return PCM_MAX;
        if (pick < 10) return PCM_MIN;
        v = $urandom;
        if (pick < 25) v = (v <<< 23) >>> 23;
        return v[SAMPLE_BITS-1:0];
    endfunction

    task automatic queue_item(input logic [ACTION_W-1:0] action, input int index,
                              input logic signed [TAP_BITS-1:0] coef,
                              input logic signed [SAMPLE_BITS-1:0] sample);
        stim_item_t it;
        it.action = action;
        it.tap_index = index[INDEX_W-1:0];
        it.coefficient = coef;
        it.sample = sample;
        item_queue.insert(item_queue.size(), it);
        items_queued++;
    endtask

    task automatic queue_random_item(input int n_eff, input int bits, output bit ignored);
        int                  roll;
        int                  index;
        logic [ACTION_W-1:0] action;
        roll = $urandom_range(99);
        if (roll < 58) action = ACT_SAMPLE;
        else if (roll < 78) action = ACT_WR_LEFT;
        else if (roll < 97) action = ACT_WR_RIGHT;
        else action = ACT_UNUSED;
        index = ($urandom_range(99) < 80) ? $urandom_range(n_eff - 1) : $urandom_range(255);
        queue_item(action, index, rand_coef(bits), rand_sample());
        ignored = (action == ACT_UNUSED);
    endtask

    task automatic wait_drained();
        while (items_taken != items_queued || stereo_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_tap_count(input int value);
        cfg_valid <= 1'b1;
        cfg_data <= value[CFG_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tap_count_reg = value[CFG_W-1:0];
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                convolve_item(on_bus);
                items_taken++;
            end
            if (!s_valid || s_ready) begin
                if (item_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    on_bus = item_queue.pop_front();
                    s_action <= on_bus.action;
                    s_tap_index <= on_bus.tap_index;
                    s_coefficient <= on_bus.coefficient;
                    s_sample_in <= on_bus.sample;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_wanted && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        fircv_result_t exp_res;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (stereo_expected.size() == 0) begin
                    $error("unexpected result transfer: left_out %0d, right_out %0d",
                           m_left_out, m_right_out);
                    mismatches++;
                end else begin
                    exp_res = stereo_expected.pop_front();
                    if (m_left_out !== exp_res.left_out) begin
                        $error("left_out: expected %0d, got %0d", exp_res.left_out,
                               m_left_out);
                        mismatches++;
                    end
                    if (m_right_out !== exp_res.right_out) begin
                        $error("right_out: expected %0d, got %0d", exp_res.right_out,
                               m_right_out);
                        mismatches++;
                    end
                    if (m_clipped !== exp_res.clipped) begin
                        $error("clipped: expected %0d, got %0d", exp_res.clipped, m_clipped);
                        mismatches++;
                    end
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int p;
        int k;
        int n_eff;
        int counted;
        bit ignored;
        foreach (hist_line[i]) begin
            hist_line[i] = '0;
            left_resp[i] = '0;
            right_resp[i] = '0;
        end
        left_resp[0] = TAP_ONE;
        right_resp[0] = TAP_ONE;
        hist_ptr = '0;
        tap_count_reg = ACTIVE_TAPS_RST;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed items at full length, starting from unit impulses: full-scale samples, half-LSB rounding, clipping.
        queue_item(ACT_SAMPLE, 0, '0, PCM_MAX);
        queue_item(ACT_SAMPLE, 0, '0, PCM_MIN);
        queue_item(ACT_SAMPLE, 0, '0, 24'sd0);
        queue_item(ACT_SAMPLE, 0, '0, 24'sd1);
        queue_item(ACT_SAMPLE, 0, '0, -24'sd1);
        queue_item(ACT_WR_LEFT, 0, TAP_MIN, '0);
        queue_item(ACT_WR_RIGHT, 0, 18'sd1, '0);
        queue_item(ACT_SAMPLE, 0, '0, PCM_MIN);
        queue_item(ACT_SAMPLE, 0, '0, 24'sd65536);
        queue_item(ACT_SAMPLE, 0, '0, -24'sd65536);
        queue_item(ACT_SAMPLE, 0, '0, -24'sd65537);
        queue_item(ACT_WR_LEFT, 255, TAP_MAX, '0);
        queue_item(ACT_WR_RIGHT, 255, TAP_MIN, '0);
        queue_item(ACT_WR_LEFT, 128, -18'sd1, '0);
        queue_item(ACT_UNUSED, 255, -18'sd1, -24'sd1);
        queue_item(ACT_SAMPLE, 0, '0, PCM_MAX);
        queue_item(ACT_WR_LEFT, 0, TAP_MAX, '0);
        queue_item(ACT_WR_RIGHT, 0, TAP_MIN, '0);
        queue_item(ACT_SAMPLE, 0, '0, PCM_MAX);
        queue_item(ACT_SAMPLE, 0, '0, PCM_MIN);
        queue_item(ACT_SAMPLE, 0, '0, 24'sh5A5A5A);
        wait_drained();

        for (p = 0; p < NUM_PHASES; p++) begin
            write_tap_count(plan_taps[p]);
            src_idle_pct <= plan_src[p];
            sink_stall_pct <= plan_sink[p];
            hold_wanted <= (plan_hold[p] != 0);
            n_eff = used_taps(plan_taps[p][CFG_W-1:0]);
            if (plan_load[p] != 0) begin
                for (k = 0; k < n_eff; k++) begin
                    queue_item(ACT_WR_LEFT, k, rand_coef(plan_bits[p]), rand_sample());
                    queue_item(ACT_WR_RIGHT, k, rand_coef(plan_bits[p]), rand_sample());
                end
            end
            counted = 0;
            while (counted < plan_items[p]) begin
                queue_random_item(n_eff, plan_bits[p], ignored);
                if (!ignored) counted++;
            end
            wait_drained();
            hold_wanted <= 1'b0;
        end

        if (mismatches == 0 && stereo_expected.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
